@@ rtl/core/anrc_pkg.sv @@
// Shared types, character codes and helpers for the ASCII radix converter.
package anrc_pkg;

  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_O     = 8'h6F;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;

  typedef enum logic [1:0] {
    RADIX_DEC = 2'd0,
    RADIX_BIN = 2'd1,
    RADIX_OCT = 2'd2,
    RADIX_HEX = 2'd3
  } radix_t;

  // start request from the parser to the formatter
  typedef struct packed {
    logic   go;
    radix_t radix;
  } fmt_start_t;

  // uppercase hex digit value, 16 for anything outside the table
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] v;
    v = 5'd16;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      v = 5'(c - CH_ZERO);
    end else if (c >= CH_UA && c <= CH_UF) begin
      v = 5'(c - CH_UA + 8'd10);
    end
    return v;
  endfunction

  // lowercase ASCII for a digit 0..15
  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = CH_ZERO + {4'd0, d};
    end else begin
      c = CH_LA + {4'd0, d} - 8'd10;
    end
    return c;
  endfunction

endpackage

@@ rtl/core/anrc_fmt.sv @@
// Formatter: serial binary-to-BCD, leading-zero skip and character emission.
module anrc_fmt import anrc_pkg::*; #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  fmt_start_t             start,
  input  logic [VALUE_WIDTH-1:0] value,
  output logic                   idle,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [7:0]             out_tdata,  // [7:0] out_char
  output logic                   out_tlast   // out_last
);

  localparam int NDEC = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int BW   = (4 * NDEC > VALUE_WIDTH) ? 4 * NDEC : VALUE_WIDTH;
  localparam int SW   = ((BW + 11) / 12) * 12;
  localparam int NNIB = SW / 4;
  localparam int CW   = $clog2(SW + 1);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_CONV = 7'b0000010,
    ST_SKIP = 7'b0000100,
    ST_PRE0 = 7'b0001000,
    ST_PRE1 = 7'b0010000,
    ST_DIG  = 7'b0100000,
    ST_NL   = 7'b1000000
  } state_t;

  state_t                 state_r, state_nxt;
  radix_t                 radix_r, radix_nxt;
  logic [VALUE_WIDTH-1:0] bin_r, bin_nxt;
  logic [SW-1:0]          dig_r, dig_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic                   ovld_r, ovld_nxt;
  logic [7:0]             ochar_r, ochar_nxt;
  logic                   olast_r, olast_nxt;

  logic [SW-1:0]          adj;
  logic [SW-1:0]          dig_shift;
  logic [3:0]             top_dig;
  logic [7:0]             pre_char;
  logic                   out_free;

  assign out_free   = !ovld_r || out_tready;
  assign idle       = (state_r == ST_IDLE);
  assign out_tvalid = ovld_r;
  assign out_tdata  = ochar_r;
  assign out_tlast  = olast_r;

  // add-3 correction on every BCD nibble
  always_comb begin
    for (int i = 0; i < NNIB; i++) begin
      adj[4*i +: 4] = (dig_r[4*i +: 4] >= 4'd5) ? dig_r[4*i +: 4] + 4'd3 : dig_r[4*i +: 4];
    end
  end

  always_comb begin
    unique case (radix_r)
      RADIX_BIN: begin
        top_dig   = {3'd0, dig_r[SW-1]};
        dig_shift = dig_r << 1;
        pre_char  = CH_B;
      end
      RADIX_OCT: begin
        top_dig   = {1'b0, dig_r[SW-1 -: 3]};
        dig_shift = dig_r << 3;
        pre_char  = CH_O;
      end
      RADIX_HEX: begin
        top_dig   = dig_r[SW-1 -: 4];
        dig_shift = dig_r << 4;
        pre_char  = CH_X;
      end
      default: begin
        top_dig   = dig_r[SW-1 -: 4];
        dig_shift = dig_r << 4;
        pre_char  = CH_ZERO;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    radix_nxt = radix_r;
    bin_nxt   = bin_r;
    dig_nxt   = dig_r;
    cnt_nxt   = cnt_r;
    ovld_nxt  = ovld_r && !out_tready;
    ochar_nxt = ochar_r;
    olast_nxt = olast_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start.go) begin
          radix_nxt = start.radix;
          bin_nxt   = value;
          unique case (start.radix)
            RADIX_DEC: begin
              dig_nxt   = '0;
              cnt_nxt   = CW'(VALUE_WIDTH);
              state_nxt = ST_CONV;
            end
            RADIX_BIN: begin
              dig_nxt   = SW'(value);
              cnt_nxt   = CW'(SW);
              state_nxt = ST_SKIP;
            end
            RADIX_OCT: begin
              dig_nxt   = SW'(value);
              cnt_nxt   = CW'(SW / 3);
              state_nxt = ST_SKIP;
            end
            default: begin
              dig_nxt   = SW'(value);
              cnt_nxt   = CW'(SW / 4);
              state_nxt = ST_SKIP;
            end
          endcase
        end
      end
      ST_CONV: begin
        dig_nxt = {adj[SW-2:0], bin_r[VALUE_WIDTH-1]};
        bin_nxt = bin_r << 1;
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          cnt_nxt   = CW'(NNIB);
          state_nxt = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (cnt_r > CW'(1) && top_dig == 4'd0) begin
          dig_nxt = dig_shift;
          cnt_nxt = cnt_r - CW'(1);
        end else if (radix_r == RADIX_DEC) begin
          state_nxt = ST_DIG;
        end else begin
          state_nxt = ST_PRE0;
        end
      end
      ST_PRE0: begin
        if (out_free) begin
          ovld_nxt  = 1'b1;
          ochar_nxt = CH_ZERO;
          olast_nxt = 1'b0;
          state_nxt = ST_PRE1;
        end
      end
      ST_PRE1: begin
        if (out_free) begin
          ovld_nxt  = 1'b1;
          ochar_nxt = pre_char;
          olast_nxt = 1'b0;
          state_nxt = ST_DIG;
        end
      end
      ST_DIG: begin
        if (out_free) begin
          ovld_nxt  = 1'b1;
          ochar_nxt = digit_char(top_dig);
          olast_nxt = 1'b0;
          dig_nxt   = dig_shift;
          cnt_nxt   = cnt_r - CW'(1);
          if (cnt_r == CW'(1)) begin
            state_nxt = ST_NL;
          end
        end
      end
      ST_NL: begin
        if (out_free) begin
          ovld_nxt  = 1'b1;
          ochar_nxt = CH_NL;
          olast_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    radix_r <= radix_nxt;
    bin_r   <= bin_nxt;
    dig_r   <= dig_nxt;
    cnt_r   <= cnt_nxt;
    ochar_r <= ochar_nxt;
    olast_r <= olast_nxt;
  end

endmodule

@@ rtl/core/ascii_number_radix_converter.sv @@
// Top level of the ASCII number radix converter: character parser plus formatter.
//
// Usage:
//   in_*  : one ASCII character per transfer; in_tlast marks the terminator (its
//           character is ignored), which closes the number. A leading '-' negates
//           a decimal number; a second character 'x' restarts in uppercase hex.
//           The value wraps modulo 2^VALUE_WIDTH.
//   out_* : optional prefix "0b"/"0o"/"0x", lowercase digits with no leading
//           zeros, then '\n' with out_tlast high.
//   cfg_* : out_radix (0 dec, 1 bin, 2 oct, 3 hex); write only while idle.
// Timing: non-terminator characters are accepted whenever the formatter is idle.
//   After the terminator in_tready stays low until the newline is loaded.
//   Decimal first runs the serial binary-to-BCD conversion over all VALUE_WIDTH
//   bits. Then the leading zero digits of the 48-bit digit register at the default
//   width are skipped (up to 47 in binary, 15 in octal, 11 in hex and decimal), the
//   skip is left, and any prefix, the digits and the newline are emitted in order.
// Reset: rst_n (synchronous, active low) clears the number state, sets decimal.
// Stall: out_tready low freezes the output register and the emit steps; the
//   conversion and skip go on, and the input stays blocked until the newline.
module ascii_number_radix_converter import anrc_pkg::*; #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,     // [7:0] in_char
  input  logic       in_tlast,     // in_last
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,    // [7:0] out_char
  output logic       out_tlast,    // out_last
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_wr_data   // [1:0] out_radix
);

  // Parser state
  logic [VALUE_WIDTH-1:0] accum_r, accum_nxt;
  logic                   minus_r, minus_nxt;
  logic                   hex_r, hex_nxt;
  logic [1:0]             pos_r, pos_nxt;
  radix_t                 radix_r;

  logic                   fmt_idle;
  logic                   in_xfer;
  fmt_start_t             fmt_start;
  logic [VALUE_WIDTH-1:0] fmt_value;
  logic [VALUE_WIDTH-1:0] dec_acc;
  logic [VALUE_WIDTH-1:0] hex_acc;

  assign in_tready = fmt_idle;
  assign in_xfer   = in_tvalid && in_tready;

  // accum*10 + (c - '0') and accum*16 + hex digit, both wrapping
  assign dec_acc = (accum_r << 3) + (accum_r << 1) + VALUE_WIDTH'(in_tdata)
                   - VALUE_WIDTH'(CH_ZERO);
  assign hex_acc = (accum_r << 4) + VALUE_WIDTH'(hex_val(in_tdata));

  // terminator hands the (possibly negated) value to the formatter
  assign fmt_start.go    = in_xfer && in_tlast;
  assign fmt_start.radix = radix_r;
  assign fmt_value       = (minus_r && !hex_r) ? (VALUE_WIDTH'(0) - accum_r) : accum_r;

  always_comb begin
    accum_nxt = accum_r;
    minus_nxt = minus_r;
    hex_nxt   = hex_r;
    pos_nxt   = pos_r;
    if (in_xfer) begin
      if (in_tlast) begin
        accum_nxt = '0;
        minus_nxt = 1'b0;
        hex_nxt   = 1'b0;
        pos_nxt   = 2'd0;
      end else begin
        priority if (pos_r == 2'd0) begin
          if (in_tdata == CH_MINUS) begin
            minus_nxt = 1'b1;
          end else begin
            accum_nxt = dec_acc;
          end
        end else if (pos_r == 2'd1 && in_tdata == CH_X) begin
          hex_nxt   = 1'b1;
          accum_nxt = '0;
        end else if (hex_r) begin
          accum_nxt = hex_acc;
        end else begin
          accum_nxt = dec_acc;
        end
        if (pos_r != 2'd3) begin
          pos_nxt = pos_r + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accum_r <= '0;
      minus_r <= 1'b0;
      hex_r   <= 1'b0;
      pos_r   <= 2'd0;
      radix_r <= RADIX_DEC;
    end else begin
      accum_r <= accum_nxt;
      minus_r <= minus_nxt;
      hex_r   <= hex_nxt;
      pos_r   <= pos_nxt;
      if (cfg_wr_en) begin
        radix_r <= radix_t'(cfg_wr_data);
      end
    end
  end

  anrc_fmt #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_fmt (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (fmt_start),
    .value      (fmt_value),
    .idle       (fmt_idle),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // Assertions
  a_busy_after_term: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready)
    else $error("input not held off after terminator");

  a_clear_after_term: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> accum_r == '0 && !minus_r && !hex_r
      && pos_r == 2'd0)
    else $error("number state not cleared after terminator");

  a_last_is_nl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata == CH_NL)
    else $error("last transfer is not a newline");

  a_pos_stays_after_sat: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r == 2'd3 && !(in_tvalid && in_tready && in_tlast) |=> pos_r == 2'd3)
    else $error("character position left saturation");

endmodule
